FILE: design/rangefinder_frame_parser_watchdog_macros.svh
// Assertion macros shared by the rangefinder frame parser RTL.
`ifndef RANGEFINDER_FRAME_PARSER_WATCHDOG_MACROS_SVH
`define RANGEFINDER_FRAME_PARSER_WATCHDOG_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define RFPW_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define RFPW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/rfpw_pkg.sv
// Shared constants, types and helpers of the rangefinder frame parser.
`default_nettype none
package rfpw_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'h55;
    localparam logic [7:0] SYNC_SECOND = 8'hAA;

    localparam logic [7:0] CMD_RANGE_A = 8'h88;
    localparam logic [7:0] CMD_RANGE_B = 8'h89;
    localparam logic [7:0] CMD_RANGE_C = 8'hB9;
    localparam logic [7:0] CMD_RANGE_D = 8'hC9;
    localparam logic [7:0] CMD_RANGE_E = 8'hF9;

    localparam logic [7:0] STATUS_OK = 8'h01;

    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    localparam logic REG_MAX_AGE = 1'b0;
    localparam logic REG_REARM   = 1'b1;

    localparam int          ApbAddrW      = 3;
    localparam int          ApbDataW      = 32;
    localparam logic [15:0] RESET_MAX_AGE = 16'd1000;
    localparam logic [15:0] RESET_REARM   = 16'd5000;

    localparam int WinDepth = 8;
    localparam int ResW     = 88;

    // Result of checking the window after the current byte is shifted in.
    typedef struct packed {
        logic        good;
        logic        bad;
        logic [7:0]  cmd;
        logic [7:0]  status;
        logic [15:0] raw;
    } t_frame_chk;

    // Watchdog verdict for the current tick.
    typedef struct packed {
        logic expire;
        logic rearm;
    } t_wdog;

    function automatic logic is_ranging(input logic [7:0] cmd);
        logic hit;
        hit = 1'b0;
        case (cmd) inside
            CMD_RANGE_A, CMD_RANGE_B, CMD_RANGE_C, CMD_RANGE_D, CMD_RANGE_E: hit = 1'b1;
            default: hit = 1'b0;
        endcase
        return hit;
    endfunction

endpackage
`default_nettype wire

FILE: design/rfpw_window.sv
// Eight-byte sliding receive window with sync and checksum detection.
`default_nettype none
module rfpw_window
    import rfpw_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire logic [7:0] i_rx_byte,
    output t_frame_chk      o_chk
);

    logic [7:0] r_win [WinDepth];
    logic [3:0] r_fill;
    logic [7:0] w_sum;
    logic       w_full;
    logic       w_sync;

    // Window after the shift: old bytes 1..7 become 0..6, the new byte is 7.
    always_comb begin
        w_sum = 8'd0;
        for (int i = 1; i < WinDepth; i++) begin
            w_sum = w_sum + r_win[i];
        end
    end

    assign w_full = (r_fill >= 4'(WinDepth - 1));
    assign w_sync = (r_win[1] == SYNC_FIRST) && (r_win[2] == SYNC_SECOND);

    always_comb begin
        o_chk.good   = w_full && w_sync && (w_sum == i_rx_byte);
        o_chk.bad    = w_full && w_sync && (w_sum != i_rx_byte);
        o_chk.cmd    = r_win[3];
        o_chk.status = r_win[4];
        o_chk.raw    = {r_win[6], r_win[7]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= 4'd0;
            for (int i = 0; i < WinDepth; i++) begin
                r_win[i] <= 8'd0;
            end
        end else if (i_step) begin
            if (o_chk.good) begin
                // Empty the window after a good frame.
                r_fill <= 4'd0;
                for (int i = 0; i < WinDepth; i++) begin
                    r_win[i] <= 8'd0;
                end
            end else begin
                if (!r_fill[3]) begin
                    r_fill <= r_fill + 4'd1;
                end
                for (int i = 0; i < WinDepth - 1; i++) begin
                    r_win[i] <= r_win[i + 1];
                end
                r_win[WinDepth - 1] <= i_rx_byte;
            end
        end
    end

endmodule
`default_nettype wire

FILE: design/rfpw_watchdog.sv
// Liveness watchdog: frame age and rearm age counted in millisecond ticks.
`default_nettype none
module rfpw_watchdog
    import rfpw_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_tick,
    input  wire logic        i_frame_good,
    input  wire logic [15:0] i_max_age,
    input  wire logic [15:0] i_rearm_to,
    output t_wdog            o_wdog
);

    logic [31:0] r_frame_age;
    logic [31:0] r_rearm_age;
    logic        r_seen;
    logic [31:0] w_frame_age_inc;
    logic [31:0] w_rearm_age_inc;

    assign w_frame_age_inc = r_frame_age + 32'd1;
    assign w_rearm_age_inc = r_rearm_age + 32'd1;

    always_comb begin
        o_wdog.expire = !r_seen || (w_frame_age_inc > {16'd0, i_max_age});
        o_wdog.rearm  = r_seen && (w_frame_age_inc > {16'd0, i_rearm_to})
                        && (w_rearm_age_inc > {16'd0, i_rearm_to});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_age <= 32'd0;
            r_rearm_age <= 32'd0;
            r_seen      <= 1'b0;
        end else if (i_frame_good) begin
            r_frame_age <= 32'd0;
            r_seen      <= 1'b1;
        end else if (i_tick) begin
            r_frame_age <= w_frame_age_inc;
            r_rearm_age <= o_wdog.rearm ? 32'd0 : w_rearm_age_inc;
        end
    end

endmodule
`default_nettype wire

FILE: design/rangefinder_frame_parser_watchdog.sv
// Top level of the rangefinder frame parser with liveness watchdog.
// Each item is either a received serial byte (tuser = 0) or a one-millisecond
// tick (tuser = 1). An accepted item lands in an input register; once the
// output register is free or draining, one registered pass checks the 8-byte
// window (sync 0x55 0xAA and an 8-bit sum over bytes 0..6 against byte 7),
// updates the cached ranging reading, the frame counters and the watchdog
// ages, and loads exactly one result into the output register. One item is
// accepted every cycle as long as the output side keeps taking results, and
// the rate is set by that single input-register to output-register pass. A
// good frame empties the window, so the next frame needs eight fresh bytes.
// Ranging commands 0x88, 0x89, 0xB9, 0xC9 and 0xF9 refresh the cached range
// (big-endian bytes 5..6, decimeters) and status; other good frames only
// refresh liveness. On ticks the reading is dropped once older than
// max_sample_age_ms (register 0, byte address 0), and after the rearm
// timeout (register 1, byte address 4) of silence a rearm request is raised,
// no more than once per timeout. Nothing fires before the first good frame.
// Write the registers only while the block is idle.
`default_nettype none
`include "rangefinder_frame_parser_watchdog_macros.svh"
module rangefinder_frame_parser_watchdog
    import rfpw_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // Slave side
    input  wire logic                i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    input  wire logic [7:0]          i_s_axis_tdata,  // [7:0] rx_byte
    input  wire logic                i_s_axis_tuser,  // [0] action
    // Master side
    output logic                     o_m_axis_tvalid,
    input  wire logic                i_m_axis_tready,
    // [15:0] range_dm, [16] quality_ok, [17] reading_valid, [18] module_state,
    // [19] frame_accepted, [20] checksum_error, [21] rearm_request,
    // [53:22] good_frames, [85:54] bad_frames, [87:86] zero
    output logic [ResW-1:0]          o_m_axis_tdata,
    // Configuration
    input  wire logic                i_psel,
    input  wire logic                i_penable,
    input  wire logic                i_pwrite,
    input  wire logic [ApbAddrW-1:0] i_paddr,
    input  wire logic [ApbDataW-1:0] i_pwdata,
    output logic [ApbDataW-1:0]      o_prdata,
    output logic                     o_pready
);

    // Configuration registers
    logic [15:0] r_max_age;
    logic [15:0] r_rearm_to;
    logic        w_cfg_wr;

    // Input register
    logic        r_in_valid;
    logic        r_in_action;
    logic [7:0]  r_in_byte;

    // Cached reading and counters
    logic [15:0] r_range;
    logic        r_qual;
    logic        r_valid;
    logic        r_state;
    logic [31:0] r_good_cnt;
    logic [31:0] r_bad_cnt;

    logic [15:0] n_range;
    logic        n_qual;
    logic        n_valid;
    logic        n_state;
    logic [31:0] n_good_cnt;
    logic [31:0] n_bad_cnt;

    // Output register
    logic            r_out_valid;
    logic [ResW-1:0] r_out_data;

    logic       w_advance;
    logic       w_is_byte;
    logic       w_is_tick;
    logic       w_good;
    logic       w_bad;
    logic       w_rearm;
    logic       w_status_ok;
    t_frame_chk w_chk;
    t_wdog      w_wdog;

    // ---------------- Configuration port ----------------
    assign o_pready = 1'b1;
    assign w_cfg_wr = i_psel && i_penable && i_pwrite && o_pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_age  <= RESET_MAX_AGE;
            r_rearm_to <= RESET_REARM;
        end else if (w_cfg_wr) begin
            unique case (i_paddr[2])
                REG_MAX_AGE: r_max_age  <= i_pwdata[15:0];
                REG_REARM:   r_rearm_to <= i_pwdata[15:0];
                default:     ;
            endcase
        end
    end

    always_comb begin
        unique case (i_paddr[2])
            REG_MAX_AGE: o_prdata = {16'd0, r_max_age};
            REG_REARM:   o_prdata = {16'd0, r_rearm_to};
            default:     o_prdata = '0;
        endcase
    end

    // ---------------- Handshake ----------------
    // Process the held item whenever the output register is free or draining.
    assign w_advance       = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || w_advance;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_action <= i_s_axis_tuser;
            r_in_byte   <= i_s_axis_tdata;
        end
    end

    assign w_is_byte = w_advance && (r_in_action == ACT_BYTE);
    assign w_is_tick = w_advance && (r_in_action == ACT_TICK);

    // ---------------- Window and watchdog ----------------
    rfpw_window u_window (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_is_byte),
        .i_rx_byte (r_in_byte),
        .o_chk     (w_chk)
    );

    assign w_good = w_is_byte && w_chk.good;
    assign w_bad  = w_is_byte && w_chk.bad;

    rfpw_watchdog u_watchdog (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_tick       (w_is_tick),
        .i_frame_good (w_good),
        .i_max_age    (r_max_age),
        .i_rearm_to   (r_rearm_to),
        .o_wdog       (w_wdog)
    );

    assign w_rearm     = w_is_tick && w_wdog.rearm;
    assign w_status_ok = (w_chk.status == STATUS_OK);

    // ---------------- Cached reading and counters ----------------
    always_comb begin
        n_range    = r_range;
        n_qual     = r_qual;
        n_valid    = r_valid;
        n_state    = r_state;
        n_good_cnt = r_good_cnt;
        n_bad_cnt  = r_bad_cnt;
        if (w_good) begin
            n_good_cnt = r_good_cnt + 32'd1;
            if (is_ranging(w_chk.cmd)) begin
                n_range = w_chk.raw;
                n_qual  = w_status_ok;
                n_valid = w_status_ok && (w_chk.raw != 16'd0);
                n_state = !(w_status_ok && (w_chk.raw != 16'd0));
            end
        end
        if (w_bad) begin
            n_bad_cnt = r_bad_cnt + 32'd1;
        end
        // Drop a stale reading, and drop it as well when the watchdog fires.
        if (w_is_tick && ((r_valid && w_wdog.expire) || w_wdog.rearm)) begin
            n_valid = 1'b0;
            n_state = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range    <= 16'd0;
            r_qual     <= 1'b0;
            r_valid    <= 1'b0;
            r_state    <= 1'b1;
            r_good_cnt <= 32'd0;
            r_bad_cnt  <= 32'd0;
        end else if (w_advance) begin
            r_range    <= n_range;
            r_qual     <= n_qual;
            r_valid    <= n_valid;
            r_state    <= n_state;
            r_good_cnt <= n_good_cnt;
            r_bad_cnt  <= n_bad_cnt;
        end
    end

    // ---------------- Output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_data <= {2'b00, n_bad_cnt, n_good_cnt, w_rearm, w_bad, w_good,
                           n_state, n_valid, n_qual, n_range};
        end
    end

    // ---------------- Assertions ----------------
    `RFPW_ASSERT_NOW(a_valid_implies_reading, i_clk, i_rst_n, r_valid,
        r_qual && (r_range != 16'd0), "valid reading without good status or range")
    `RFPW_ASSERT_NOW(a_state_tracks_valid, i_clk, i_rst_n, 1'b1,
        r_state != r_valid, "module state disagrees with reading validity")
    `RFPW_ASSERT_NEXT(a_good_count_bumps, i_clk, i_rst_n, w_good,
        r_good_cnt == $past(r_good_cnt) + 32'd1, "good frame not counted")
    `RFPW_ASSERT_NEXT(a_stalled_item_held, i_clk, i_rst_n, r_in_valid && !w_advance,
        r_in_valid, "held input item lost while output stalled")

endmodule
`default_nettype wire

FILE: tb/sv/tb_rangefinder_frame_parser_watchdog.sv
// Self-checking testbench for the rangefinder frame parser with liveness watchdog.
`timescale 1ns / 100ps

import rfpw_pkg::*;

// One output report, laid out as the master-side tdata bus.
typedef struct packed {
    logic [1:0]  pad;
    logic [31:0] bad_frames;
    logic [31:0] good_frames;
    logic        rearm_request;
    logic        checksum_error;
    logic        frame_accepted;
    logic        module_state;
    logic        reading_valid;
    logic        quality_ok;
    logic [15:0] range_dm;
} report_t;

// Mirrors the parser and watchdog state and holds the reports still due.
class parser_mirror;
    logic [15:0] max_age_ms;
    logic [15:0] rearm_ms;
    logic [7:0]  win [8];
    int unsigned fill;
    logic [15:0] range_dm;
    logic        quality;
    logic        valid;
    logic        degraded;
    logic [31:0] good_cnt;
    logic [31:0] bad_cnt;
    logic [31:0] now_ms;
    logic [31:0] last_frame_ms;
    logic        seen_frame;
    logic [31:0] last_rearm_ms;
    report_t     due_reports[$];
    int          errors;

    function new();
        max_age_ms    = RESET_MAX_AGE;
        rearm_ms      = RESET_REARM;
        foreach (win[i]) win[i] = 8'h00;
        fill          = 0;
        range_dm      = '0;
        quality       = 1'b0;
        valid         = 1'b0;
        degraded      = 1'b1;
        good_cnt      = '0;
        bad_cnt       = '0;
        now_ms        = '0;
        last_frame_ms = '0;
        seen_frame    = 1'b0;
        last_rearm_ms = '0;
        errors        = 0;
    endfunction

    function void set_reg(input logic idx, input logic [15:0] val);
        if (idx == REG_MAX_AGE) max_age_ms = val;
        else                    rearm_ms   = val;
    endfunction

    // Advance the mirror by one accepted item and queue the report it causes.
    function void note_item(input logic act, input logic [7:0] rx);
        report_t     r;
        logic [7:0]  sum;
        logic [7:0]  cmd;
        logic [15:0] raw;
        logic [31:0] age;
        r = '0;
        if (act == ACT_BYTE) begin
            for (int i = 0; i < 7; i++) win[i] = win[i + 1];
            win[7] = rx;
            if (fill < 8) fill++;
            if (fill >= 8 && win[0] == SYNC_FIRST && win[1] == SYNC_SECOND) begin
                sum = 8'h00;
                for (int i = 0; i < 7; i++) sum += win[i];
                if (sum != win[7]) begin
                    // bad sum: count it, keep the window sliding
                    bad_cnt++;
                    r.checksum_error = 1'b1;
                end else begin
                    cmd = win[2];
                    raw = {win[5], win[6]};
                    r.frame_accepted = 1'b1;
                    good_cnt++;
                    last_frame_ms = now_ms;
                    seen_frame    = 1'b1;
                    if (cmd == CMD_RANGE_A || cmd == CMD_RANGE_B || cmd == CMD_RANGE_C ||
                        cmd == CMD_RANGE_D || cmd == CMD_RANGE_E) begin
                        range_dm = raw;
                        quality  = (win[3] == STATUS_OK);
                        valid    = (win[3] == STATUS_OK) && (raw != 16'h0000);
                        degraded = !valid;
                    end
                    fill = 0;
                    foreach (win[i]) win[i] = 8'h00;
                end
            end
        end else begin
            now_ms++;
            age = now_ms - last_frame_ms;
            if (valid && (!seen_frame || age > {16'h0, max_age_ms})) begin
                valid    = 1'b0;
                degraded = 1'b1;
            end
            if (seen_frame && age > {16'h0, rearm_ms} &&
                (now_ms - last_rearm_ms) > {16'h0, rearm_ms}) begin
                r.rearm_request = 1'b1;
                last_rearm_ms   = now_ms;
                valid           = 1'b0;
                degraded        = 1'b1;
            end
        end
        r.range_dm      = range_dm;
        r.quality_ok    = quality;
        r.reading_valid = valid;
        r.module_state  = degraded;
        r.good_frames   = good_cnt;
        r.bad_frames    = bad_cnt;
        due_reports.push_back(r);
    endfunction

    function void compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // Match one report from the block against the oldest one due.
    function void check_report(input logic [ResW-1:0] word);
        report_t got;
        report_t want;
        got = word;
        if (due_reports.size() == 0) begin
            $display("%0t: report with nothing due, expected none, actual %h", $time, word);
            errors++;
            return;
        end
        want = due_reports.pop_front();
        compare_field("range_dm", want.range_dm, got.range_dm);
        compare_field("quality_ok", want.quality_ok, got.quality_ok);
        compare_field("reading_valid", want.reading_valid, got.reading_valid);
        compare_field("module_state", want.module_state, got.module_state);
        compare_field("frame_accepted", want.frame_accepted, got.frame_accepted);
        compare_field("checksum_error", want.checksum_error, got.checksum_error);
        compare_field("rearm_request", want.rearm_request, got.rearm_request);
        compare_field("good_frames", want.good_frames, got.good_frames);
        compare_field("bad_frames", want.bad_frames, got.bad_frames);
        compare_field("pad", want.pad, got.pad);
    endfunction
endclass

module tb_rangefinder_frame_parser_watchdog;

    // Byte addresses of the two registers.
    localparam logic [ApbAddrW-1:0] ADDR_MAX_AGE = {REG_MAX_AGE, 2'b00};
    localparam logic [ApbAddrW-1:0] ADDR_REARM   = {REG_REARM, 2'b00};
    // Hard stop, far above the slowest legal run of ~750 items.
    localparam int CYCLE_LIMIT = 200000;

    logic                i_clk;
    logic                i_rst_n   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic [7:0]          s_tdata   = 8'h00;
    logic                s_tuser   = ACT_BYTE;
    logic                m_tready  = 1'b0;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [ApbAddrW-1:0] paddr     = '0;
    logic [ApbDataW-1:0] pwdata    = '0;

    logic                o_s_axis_tready;
    logic                o_m_axis_tvalid;
    logic [ResW-1:0]     o_m_axis_tdata;
    logic [ApbDataW-1:0] o_prdata;
    logic                o_pready;

    // calm turns off idling on both sides for a long stretch.
    bit          calm        = 1'b0;
    int unsigned items_sent  = 0;
    int unsigned cycle_count = 0;

    logic [7:0] ranging_cmds [5] = '{CMD_RANGE_A, CMD_RANGE_B, CMD_RANGE_C,
                                     CMD_RANGE_D, CMD_RANGE_E};

    parser_mirror mirror = new();

    rangefinder_frame_parser_watchdog dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_tdata),   // [7:0] rx_byte
        .i_s_axis_tuser  (s_tuser),   // [0] action
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .o_prdata        (o_prdata),
        .o_pready        (o_pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Stall the result side about 21 times in a hundred, unless calm.
    always @(posedge i_clk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= 21);
    end

    // Watch both handshakes at each edge: note inputs first, then check results.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_tvalid && o_s_axis_tready) mirror.note_item(s_tuser, s_tdata);
            if (o_m_axis_tvalid && m_tready) mirror.check_report(o_m_axis_tdata);
        end
    end

    // Give up on a hung run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d reports still due", $time,
                     mirror.due_reports.size());
            $display("** rangefinder_frame_parser_watchdog: FAILED **");
            $finish;
        end
    end

    // Offer one item and hold it until taken; idle randomly before it.
    task automatic push_item(input logic act, input logic [7:0] data);
        while (!calm && $urandom_range(0, 99) < 21) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= data;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic push_tick();
        // rx_byte is random on ticks and must be ignored
        push_item(ACT_TICK, 8'($urandom_range(0, 255)));
    endtask

    // Send one frame; flip != 0 corrupts the checksum byte. Ticks may fall
    // between the bytes, which the window must not notice.
    task automatic push_frame(input logic [7:0] cmd, input logic [7:0] status,
                              input logic [7:0] spare, input logic [15:0] raw,
                              input logic [7:0] flip, input bit with_ticks);
        logic [7:0] fb [8];
        fb[0] = SYNC_FIRST;
        fb[1] = SYNC_SECOND;
        fb[2] = cmd;
        fb[3] = status;
        fb[4] = spare;
        fb[5] = raw[15:8];
        fb[6] = raw[7:0];
        fb[7] = 8'h00;
        for (int i = 0; i < 7; i++) fb[7] += fb[i];
        fb[7] ^= flip;
        for (int i = 0; i < 8; i++) begin
            if (with_ticks && $urandom_range(0, 99) < 10) push_tick();
            push_item(ACT_BYTE, fb[i]);
        end
    endtask

    // Drop valid and wait until every report due has come back; the first
    // edge lets the monitor note the last accepted item.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (mirror.due_reports.size() != 0) @(posedge i_clk);
    endtask

    // Write one register, then read it back.
    task automatic write_reg(input logic [ApbAddrW-1:0] addr, input logic [15:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= {16'h0000, val};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!o_pready) @(posedge i_clk);
        mirror.set_reg(addr[2], val);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!o_pready) @(posedge i_clk);
        if (o_prdata[15:0] !== val) begin
            $display("%0t: readback at %0d, expected %0h, actual %0h", $time, addr, val,
                     o_prdata[15:0]);
            mirror.errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input logic [15:0] max_age, input logic [15:0] rearm);
        drain();
        write_reg(ADDR_MAX_AGE, max_age);
        write_reg(ADDR_REARM, rearm);
    endtask

    // Mostly well-formed frames with random content, mixed with tick bursts,
    // line noise and truncated frames.
    task automatic run_traffic(input int unsigned count, input int unsigned max_burst);
        int unsigned start;
        int unsigned pick;
        int unsigned len;
        logic [7:0]  cmd;
        logic [7:0]  status;
        logic [15:0] raw;
        logic [7:0]  flip;
        start = items_sent;
        while (items_sent - start < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                cmd    = ($urandom_range(0, 99) < 65) ? ranging_cmds[$urandom_range(0, 4)]
                                                      : 8'($urandom_range(0, 255));
                status = ($urandom_range(0, 99) < 60) ? STATUS_OK : 8'($urandom_range(0, 255));
                raw    = ($urandom_range(0, 99) < 15) ? 16'h0000 : 16'($urandom_range(0, 65535));
                flip   = ($urandom_range(0, 99) < 15) ? 8'($urandom_range(1, 255)) : 8'h00;
                push_frame(cmd, status, 8'($urandom_range(0, 255)), raw, flip,
                           1'($urandom_range(0, 1)));
            end else if (pick < 72) begin
                len = $urandom_range(1, max_burst);
                repeat (len) push_tick();
            end else if (pick < 84) begin
                len = $urandom_range(1, 4);
                repeat (len) push_item(ACT_BYTE, 8'($urandom_range(0, 255)));
            end else begin
                // first sync byte, usually the second one too, then a frame cut short
                push_item(ACT_BYTE, SYNC_FIRST);
                if ($urandom_range(0, 3) != 0) push_item(ACT_BYTE, SYNC_SECOND);
                len = $urandom_range(0, 5);
                repeat (len) push_item(ACT_BYTE, 8'($urandom_range(0, 255)));
            end
        end
    endtask

    initial begin
        // Hold reset, then release it for good.
        i_rst_n <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: full-scale ranging frame at reset settings, ticks carrying
        // a stray byte, a bad checksum, then an all-ones non-ranging frame.
        push_frame(CMD_RANGE_A, STATUS_OK, 8'h00, 16'hFFFF, 8'h00, 1'b0);
        push_item(ACT_TICK, 8'hFF);
        push_item(ACT_TICK, 8'h00);
        push_frame(8'h10, 8'h00, 8'h00, 16'h0000, 8'hFF, 1'b0);
        push_frame(8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 8'h00, 1'b0);

        // Zero limits: stale on the first tick, watchdog on every tick.
        configure(16'h0000, 16'h0000);
        run_traffic(110, 6);

        // Widest limits, with both sides running flat out.
        configure(16'hFFFF, 16'hFFFF);
        calm = 1'b1;
        run_traffic(110, 20);
        calm = 1'b0;

        // Short random limits so that aging and rearm happen often.
        repeat (4) begin
            configure(16'($urandom_range(0, 12)), 16'($urandom_range(0, 40)));
            run_traffic(115, 45);
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (mirror.errors == 0) begin
            $display("** rangefinder_frame_parser_watchdog: PASSED **");
        end else begin
            $display("** rangefinder_frame_parser_watchdog: FAILED **");
        end
        $finish;
    end

endmodule
